/* rtl/owner_tagged_index_allocator_assert.svh */
// Assertion macros for the owner-tagged index allocator.
// Each macro expands to one labeled concurrent assertion; no other dependencies.
`ifndef OWNER_TAGGED_INDEX_ALLOCATOR_ASSERT_SVH
`define OWNER_TAGGED_INDEX_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define OTI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define OTI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/oti_pkg.sv */
// Shared constants for the owner-tagged index allocator.
// No dependencies.
`default_nettype none

package oti_pkg;

  localparam int NUM_INDICES_DEF = 256;
  localparam int OWNER_BITS_DEF  = 32;
  // tags compared per cycle during a sweep
  localparam int SWEEP_LANES     = 16;

  localparam int MODE_W     = 2;
  localparam int OWNER_ID_W = 32;
  localparam int SLOT_W     = 8;
  localparam int QUOTA_W    = 9;
  localparam int COUNT_W    = 9;
  localparam int RESID_W    = 10;
  localparam int REFUSED_W  = 32;

  localparam logic [QUOTA_W-1:0] QUOTA_RESET = 9'd256;

  localparam logic [MODE_W-1:0] MODE_ALLOC     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE_ONE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE_OWN  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FREE_ALL  = 2'd3;

endpackage

`default_nettype wire

/* rtl/owner_tagged_index_allocator.sv */
// Owner-tagged lowest-free index allocator with a quota register.
// Allocate and free-owner sweep the tag memory rows in order, allocate stopping
// at the first free lane; free-one reads one row; quota refusal, bad slot and
// free-all reply without a sweep. ROWS = NUM_INDICES / 16, 16 tags per cycle.
// Next start is taken the cycle after done. Reset clears the map, counts and
// sets the quota to 256; the tag memory is not cleared. Results cannot stall.
`default_nettype none
`include "owner_tagged_index_allocator_assert.svh"

module owner_tagged_index_allocator
  import oti_pkg::*;
#(
  parameter int NUM_INDICES = NUM_INDICES_DEF,
  parameter int OWNER_BITS  = OWNER_BITS_DEF
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        cfg_we,
  input  wire  [QUOTA_W-1:0]         cfg_wdata,
  input  wire                        start,
  output logic                       busy,
  input  wire  [MODE_W-1:0]          mode,
  input  wire  [OWNER_ID_W-1:0]      owner_id,
  input  wire  [SLOT_W-1:0]          slot_index,
  output logic                       done,
  output logic                       ok,
  output logic [SLOT_W-1:0]          granted_index,
  output logic [COUNT_W-1:0]         in_use_count,
  output logic signed [RESID_W-1:0]  residual_capacity,
  output logic [REFUSED_W-1:0]       refused_total
);

  localparam int LANES_P2 = 2 ** $clog2(NUM_INDICES);
  localparam int LANES    = (LANES_P2 < SWEEP_LANES) ? LANES_P2 : SWEEP_LANES;
  localparam int LW       = $clog2(LANES);
  localparam int ROWS     = (NUM_INDICES + LANES - 1) / LANES;
  localparam int RW       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int XW       = RW + LW;
  localparam int CW       = $clog2(NUM_INDICES + 1);
  localparam int DW       = ((CW > QUOTA_W) ? CW : QUOTA_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_REPLY = 3'b100
  } state_t;

  state_t                  state;
  logic [QUOTA_W-1:0]      max_size;
  logic [ROWS*LANES-1:0]   alloc_map;
  logic [CW-1:0]           in_use;
  logic [REFUSED_W-1:0]    refused_counter;

  logic [MODE_W-1:0]       op_mode;
  logic [OWNER_BITS-1:0]   key;
  logic [LANES-1:0]        lane_mask;
  logic [RW-1:0]           rd_row;
  logic [RW-1:0]           end_row;
  logic                    rd_active;
  logic                    cmp_vld;
  logic [RW-1:0]           cmp_row;
  logic                    hit;
  logic                    ok_r;
  logic [XW-1:0]           grant_r;

  logic [OWNER_BITS-1:0]   tag_mem [ROWS][LANES];
  logic [OWNER_BITS-1:0]   tag_row [LANES];

  // shared row compare unit
  logic [LANES-1:0]        row_bits;
  logic [LANES-1:0]        lane_vld;
  logic [LANES-1:0]        free_v;
  logic [LANES-1:0]        match_v;
  logic                    free_any;
  logic [LW-1:0]           free_lane;
  logic [LW:0]             match_cnt;
  logic [LANES-1:0]        set_v;
  logic                    last_row;
  logic                    tag_we;

  logic [OWNER_BITS-1:0]   owner_key;
  logic [XW+SLOT_W-1:0]    slot_wide;
  logic                    slot_ok;
  logic                    quota_hit;

  assign owner_key = OWNER_BITS'(owner_id);
  assign slot_wide = (XW + SLOT_W)'(slot_index);
  assign slot_ok   = ({24'd0, slot_index} < 32'(NUM_INDICES));
  assign quota_hit = (DW'(in_use) >= DW'(max_size));

  always_comb begin
    logic [XW-1:0] lane_idx;
    lane_idx  = '0;
    row_bits  = alloc_map[{cmp_row, {LW{1'b0}}} +: LANES];
    free_lane = '0;
    match_cnt = '0;
    for (int l = 0; l < LANES; l++) begin
      lane_idx    = {cmp_row, LW'(l)};
      lane_vld[l] = ({1'b0, lane_idx} < (XW + 1)'(NUM_INDICES));
      match_v[l]  = row_bits[l] & lane_vld[l] & lane_mask[l] & (tag_row[l] == key);
    end
    free_v   = ~row_bits & lane_vld;
    free_any = |free_v;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (free_v[l]) begin
        free_lane = LW'(l);
      end
    end
    for (int l = 0; l < LANES; l++) begin
      match_cnt = match_cnt + (LW + 1)'(match_v[l]);
    end
    set_v = '0;
    set_v[free_lane] = free_any;
  end

  assign last_row = (cmp_row == end_row);
  assign tag_we   = (state == ST_SWEEP) && cmp_vld && (op_mode == MODE_ALLOC) && free_any;

  // tag memory: one lane written, one row read per cycle
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[cmp_row][free_lane] <= key;
    end
    tag_row <= tag_mem[rd_row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      max_size        <= QUOTA_RESET;
      alloc_map       <= '0;
      in_use          <= '0;
      refused_counter <= '0;
      rd_active       <= 1'b0;
      cmp_vld         <= 1'b0;
      ok_r            <= 1'b0;
      grant_r         <= '0;
      hit             <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_size <= cfg_wdata;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            op_mode   <= mode;
            key       <= owner_key;
            hit       <= 1'b0;
            grant_r   <= '0;
            ok_r      <= 1'b0;
            rd_row    <= '0;
            end_row   <= RW'(ROWS - 1);
            lane_mask <= '1;
            case (mode)
              MODE_ALLOC: begin
                if (quota_hit) begin
                  if (refused_counter != '1) begin
                    refused_counter <= refused_counter + 1'b1;
                  end
                  state <= ST_REPLY;
                end else begin
                  rd_active <= 1'b1;
                  state     <= ST_SWEEP;
                end
              end
              MODE_FREE_ONE: begin
                if (slot_ok) begin
                  rd_row    <= slot_wide[LW +: RW];
                  end_row   <= slot_wide[LW +: RW];
                  lane_mask <= LANES'(1) << slot_wide[LW-1:0];
                  rd_active <= 1'b1;
                  state     <= ST_SWEEP;
                end else begin
                  state <= ST_REPLY;
                end
              end
              MODE_FREE_OWN: begin
                rd_active <= 1'b1;
                state     <= ST_SWEEP;
              end
              default: begin
                alloc_map <= '0;
                in_use    <= '0;
                ok_r      <= 1'b1;
                state     <= ST_REPLY;
              end
            endcase
          end
        end
        ST_SWEEP: begin
          // issue the next row read while comparing the previous one
          cmp_row <= rd_row;
          cmp_vld <= rd_active;
          if (rd_active) begin
            if (rd_row == end_row) begin
              rd_active <= 1'b0;
            end else begin
              rd_row <= rd_row + 1'b1;
            end
          end
          if (cmp_vld) begin
            if (op_mode == MODE_ALLOC) begin
              if (free_any) begin
                alloc_map[{cmp_row, {LW{1'b0}}} +: LANES] <= row_bits | set_v;
                in_use    <= in_use + 1'b1;
                ok_r      <= 1'b1;
                grant_r   <= {cmp_row, free_lane};
                rd_active <= 1'b0;
                cmp_vld   <= 1'b0;
                state     <= ST_REPLY;
              end else if (last_row) begin
                // table full below quota: not a quota refusal
                cmp_vld <= 1'b0;
                state   <= ST_REPLY;
              end
            end else begin
              alloc_map[{cmp_row, {LW{1'b0}}} +: LANES] <= row_bits & ~match_v;
              in_use <= in_use - CW'(match_cnt);
              hit    <= hit | (|match_v);
              if (last_row) begin
                ok_r    <= hit | (|match_v);
                cmp_vld <= 1'b0;
                state   <= ST_REPLY;
              end
            end
          end
        end
        ST_REPLY: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  logic [DW-1:0]        resid_w;
  logic [DW-1:0]        count_w;
  logic [XW+SLOT_W-1:0] grant_w;

  assign resid_w = DW'(max_size) - DW'(in_use);
  assign count_w = DW'(in_use);
  assign grant_w = (XW + SLOT_W)'(grant_r);

  assign busy              = (state != ST_IDLE);
  assign done              = (state == ST_REPLY);
  assign ok                = ok_r;
  assign granted_index     = grant_w[SLOT_W-1:0];
  assign in_use_count      = count_w[COUNT_W-1:0];
  assign residual_capacity = resid_w[RESID_W-1:0];
  assign refused_total     = refused_counter;

  `OTI_ASSERT_NEXT(a_done_then_idle, clk, rst, done, !busy, "busy after result")
  `OTI_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accept did not start work")
  `OTI_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, DW'(in_use) <= DW'(NUM_INDICES), "count over size")
  `OTI_ASSERT_IMPL(a_clear_ok, clk, rst, done && (op_mode == MODE_FREE_ALL), ok && (in_use == '0), "free-all result wrong")

endmodule

`default_nettype wire

/* test/owner_tagged_index_allocator_checker.sv */
// Result checker for the owner-tagged index allocator: tracks the slot table,
// quota and refusal count, predicts each result and compares it on done.
// Depends on oti_pkg for widths and mode codes.
`timescale 1ns / 1ps

module owner_tagged_index_allocator_checker
  import oti_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [QUOTA_W-1:0]        cfg_wdata,
  input  logic                      start,
  input  logic                      busy,
  input  logic [MODE_W-1:0]         mode,
  input  logic [OWNER_ID_W-1:0]     owner_id,
  input  logic [SLOT_W-1:0]         slot_index,
  input  logic                      done,
  input  logic                      ok,
  input  logic [SLOT_W-1:0]         granted_index,
  input  logic [COUNT_W-1:0]        in_use_count,
  input  logic [RESID_W-1:0]        residual_capacity,
  input  logic [REFUSED_W-1:0]      refused_total,
  output int                        errors,
  output int                        pending
);

  typedef struct packed {
    logic                 ok;
    logic [SLOT_W-1:0]    index;
    logic [COUNT_W-1:0]   count;
    logic [RESID_W-1:0]   resid;
    logic [REFUSED_W-1:0] refused;
  } outcome_t;

  logic [QUOTA_W-1:0]    quota;
  bit                    held [NUM_INDICES_DEF];
  logic [OWNER_ID_W-1:0] holder [NUM_INDICES_DEF];
  int unsigned           held_count;
  logic [REFUSED_W-1:0]  refusals;
  outcome_t              awaited_results[$];

  initial begin
    errors = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("%0t ns: %s mismatch, got %0h, want %0h", $time, field, got, want);
  endtask

  function automatic outcome_t apply_op(input logic [MODE_W-1:0] op,
                                        input logic [OWNER_ID_W-1:0] who,
                                        input logic [SLOT_W-1:0] slot);
    outcome_t r;
    int       diff;
    bit       found;
    r = '0;
    found = 1'b0;
    case (op)
      MODE_ALLOC: begin
        if (held_count >= quota) begin
          if (refusals != '1) refusals++;
        end else begin
          // lowest free slot wins; a full table refuses without counting
          for (int i = 0; i < NUM_INDICES_DEF; i++) begin
            if (!found && !held[i]) begin
              found = 1'b1;
              held[i] = 1'b1;
              holder[i] = who;
              held_count++;
              r.ok = 1'b1;
              r.index = SLOT_W'(i);
            end
          end
        end
      end
      MODE_FREE_ONE: begin
        if (slot < NUM_INDICES_DEF && held[slot] && holder[slot] == who) begin
          held[slot] = 1'b0;
          held_count--;
          r.ok = 1'b1;
        end
      end
      MODE_FREE_OWN: begin
        for (int i = 0; i < NUM_INDICES_DEF; i++) begin
          if (held[i] && holder[i] == who) begin
            held[i] = 1'b0;
            held_count--;
            r.ok = 1'b1;
          end
        end
      end
      MODE_FREE_ALL: begin
        for (int i = 0; i < NUM_INDICES_DEF; i++) held[i] = 1'b0;
        held_count = 0;
        r.ok = 1'b1;
      end
    endcase
    diff = int'(quota) - int'(held_count);
    r.count = COUNT_W'(held_count);
    r.resid = RESID_W'(diff);
    r.refused = refusals;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      quota = QUOTA_RESET;
      for (int i = 0; i < NUM_INDICES_DEF; i++) held[i] = 1'b0;
      held_count = 0;
      refusals = '0;
      awaited_results.delete();
    end else begin
      if (cfg_we) quota = cfg_wdata;
      if (start && !busy) awaited_results.push_back(apply_op(mode, owner_id, slot_index));
      if (done) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unrequested result", 32'd1, 32'd0);
        end else begin
          want = awaited_results.pop_front();
          if (ok !== want.ok) report_mismatch("ok", 32'(ok), 32'(want.ok));
          if (granted_index !== want.index)
            report_mismatch("granted_index", 32'(granted_index), 32'(want.index));
          if (in_use_count !== want.count)
            report_mismatch("in_use_count", 32'(in_use_count), 32'(want.count));
          if (residual_capacity !== want.resid)
            report_mismatch("residual_capacity", 32'(residual_capacity), 32'(want.resid));
          if (refused_total !== want.refused)
            report_mismatch("refused_total", refused_total, want.refused);
        end
      end
    end
    pending = awaited_results.size();
  end

endmodule

/* test/owner_tagged_index_allocator_test.sv */
// Testbench top for the owner-tagged index allocator: clock, reset, quota
// writes and operation stimulus; checking is done by the checker module.
// Depends on oti_pkg, owner_tagged_index_allocator and its checker.
`timescale 1ns / 1ps

module owner_tagged_index_allocator_test;
  import oti_pkg::*;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [QUOTA_W-1:0]        cfg_wdata;
  logic                      start;
  logic                      busy;
  logic [MODE_W-1:0]         mode;
  logic [OWNER_ID_W-1:0]     owner_id;
  logic [SLOT_W-1:0]         slot_index;
  logic                      done;
  logic                      ok;
  logic [SLOT_W-1:0]         granted_index;
  logic [COUNT_W-1:0]        in_use_count;
  logic signed [RESID_W-1:0] residual_capacity;
  logic [REFUSED_W-1:0]      refused_total;
  int                        errors;
  int                        pending;
  bit                        gaps_on;

  owner_tagged_index_allocator dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .start             (start),
    .busy              (busy),
    .mode              (mode),
    .owner_id          (owner_id),
    .slot_index        (slot_index),
    .done              (done),
    .ok                (ok),
    .granted_index     (granted_index),
    .in_use_count      (in_use_count),
    .residual_capacity (residual_capacity),
    .refused_total     (refused_total)
  );

  owner_tagged_index_allocator_checker checker_i (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .start             (start),
    .busy              (busy),
    .mode              (mode),
    .owner_id          (owner_id),
    .slot_index        (slot_index),
    .done              (done),
    .ok                (ok),
    .granted_index     (granted_index),
    .in_use_count      (in_use_count),
    .residual_capacity (residual_capacity),
    .refused_total     (refused_total),
    .errors            (errors),
    .pending           (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Hold start until the transfer edge; sample busy at the falling edge.
  task automatic issue_op(input logic [MODE_W-1:0] op, input logic [OWNER_ID_W-1:0] who,
                          input logic [SLOT_W-1:0] slot);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    start <= 1'b1;
    mode <= op;
    owner_id <= who;
    slot_index <= slot;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  // Write the quota only once every result is back.
  task automatic set_quota(input logic [QUOTA_W-1:0] q);
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= q;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_ops(input int count, input int w_alloc, input int w_one,
                            input int w_own);
    logic [OWNER_ID_W-1:0] pool [4];
    logic [MODE_W-1:0]     op;
    logic [OWNER_ID_W-1:0] who;
    logic [SLOT_W-1:0]     slot;
    int                    pick;
    pool[0] = '0;
    pool[1] = '1;
    pool[2] = $urandom;
    pool[3] = $urandom;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < w_alloc) op = MODE_ALLOC;
      else if (pick < w_alloc + w_one) op = MODE_FREE_ONE;
      else if (pick < w_alloc + w_one + w_own) op = MODE_FREE_OWN;
      else op = MODE_FREE_ALL;
      // a small owner pool keeps frees hitting held slots; the rest is noise
      who = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, 3)];
      slot = ($urandom_range(0, 2) == 0) ? SLOT_W'($urandom) : SLOT_W'($urandom_range(0, 31));
      issue_op(op, who, slot);
    end
  endtask

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    start = 1'b0;
    mode = MODE_ALLOC;
    owner_id = '0;
    slot_index = '0;
    gaps_on = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset quota, ownership checks, lowest-free reuse
    issue_op(MODE_FREE_ALL, '0, '0);
    issue_op(MODE_ALLOC, 32'h0000_0000, '0);
    issue_op(MODE_ALLOC, 32'hFFFF_FFFF, '0);
    issue_op(MODE_ALLOC, 32'h5A5A_5A5A, '0);
    issue_op(MODE_ALLOC, 32'h0000_0000, '0);
    issue_op(MODE_FREE_ONE, 32'h0000_0000, 8'd1);
    issue_op(MODE_FREE_ONE, 32'hFFFF_FFFF, 8'd1);
    issue_op(MODE_FREE_ONE, 32'hFFFF_FFFF, 8'd1);
    issue_op(MODE_FREE_ONE, 32'h0000_0000, 8'd255);
    issue_op(MODE_ALLOC, 32'hA5A5_A5A5, '0);
    issue_op(MODE_FREE_OWN, 32'h0000_0000, '0);
    issue_op(MODE_FREE_OWN, 32'h0000_0000, '0);
    issue_op(MODE_FREE_OWN, 32'h1234_5678, 8'hFF);
    issue_op(MODE_ALLOC, 32'h0000_0000, 8'hFF);
    // quota below use: refusal counted, residual negative
    set_quota(9'd0);
    issue_op(MODE_ALLOC, 32'h0000_0000, '0);
    issue_op(MODE_FREE_ONE, 32'h0000_0000, 8'd0);
    set_quota(9'd2);
    issue_op(MODE_ALLOC, 32'hFFFF_FFFF, '0);
    issue_op(MODE_FREE_ALL, 32'hFFFF_FFFF, 8'hAA);
    issue_op(MODE_ALLOC, 32'h8000_0001, '0);
    issue_op(MODE_ALLOC, 32'h7FFF_FFFE, '0);
    issue_op(MODE_ALLOC, 32'h8000_0001, '0);
    issue_op(MODE_FREE_ALL, '0, '0);

    set_quota(9'd256);
    random_ops(170, 55, 28, 14);
    set_quota(9'd8);
    random_ops(100, 55, 28, 14);
    // fill the whole table under a quota above its size
    issue_op(MODE_FREE_ALL, '0, '0);
    set_quota(9'd511);
    random_ops(265, 100, 0, 0);
    set_quota(9'd0);
    random_ops(20, 50, 30, 15);
    set_quota(9'd100);
    random_ops(150, 30, 40, 28);
    set_quota(9'd1);
    random_ops(60, 50, 30, 15);
    set_quota(QUOTA_W'($urandom_range(0, 256)));
    random_ops(200, 55, 28, 14);
    gaps_on = 1'b0;
    set_quota(9'd256);
    random_ops(150, 55, 28, 14);

    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
